// ===== rtl/dss_pkg.sv =====
`timescale 1ns / 1ps
package dss_pkg;

	localparam int MAX_REQUESTS_DEF = 32;
	localparam int TRACK_BITS_DEF   = 16;

	localparam int TRK_W   = 16;
	localparam int TOTAL_W = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 72;

	localparam logic [CFG_IDX_W-1:0] CFG_DISK_MAX   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd2;

	localparam logic [CFG_DATA_W-1:0] DISK_MAX_RST = 16'd199;

	localparam logic [1:0] POL_FCFS  = 2'd0;
	localparam logic [1:0] POL_SCAN  = 2'd1;
	localparam logic [1:0] POL_CSCAN = 2'd2;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PASS,
		B_EMIT
	} back_state_t;

	typedef enum logic [2:0] {
		SEG_FCFS,
		SEG_HI,
		SEG_TOP,
		SEG_ZERO,
		SEG_LO
	} seg_t;

endpackage

// ===== rtl/disk_seek_scheduler.sv =====
`timescale 1ns / 1ps
// disk seek scheduler
// input stream: one track request per transfer, tlast closes the batch.
// requests load at one per cycle into a request store of MAX_REQUESTS
// entries; requests past a full store are dropped, a dropped tlast still
// closes the batch. tracks above disk_max are clamped to disk_max.
// after tlast the planner walks the store and emits one record per head
// move (from, to, distance, running total), tlast on the final record.
// every policy picks each next request by a full pass over the store (FCFS
// takes the oldest unused entry), one entry read a cycle from the store's
// single read port; the SCAN/C-SCAN moves to disk_max and to 0 take no pass.
// while a plan runs the input side holds tready low; the output register
// holds a record until it is taken, and the planner waits behind it.
// configuration: cfg_index 0 disk_max, 1 start_head, 2 policy
// (0 FCFS, 1 SCAN, 2 C-SCAN, 3 as FCFS); write only while idle.
// reset: disk_max 199, start_head 0, policy FCFS, empty batch.
module disk_seek_scheduler #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF,
	parameter int TRACK_BITS   = dss_pkg::TRACK_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dss_pkg::IN_DATA_W-1:0]     s_tdata,   // track[15:0]
	input  logic                              s_tlast,   // last_request
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// from_track[15:0], to_track[31:16], distance[47:32], total_seek[69:48]
	output logic [dss_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast,   // done_res
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dss_pkg::*;

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int JW = 2 + CW + 2 * TRACK_BITS;

	logic [CFG_DATA_W-1:0] disk_max_q, start_head_q;
	logic [1:0]            policy_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [TRACK_BITS-1:0] ram_wdata, ram_rdata;
	logic                  job_push, job_empty, back_active, busy;
	logic [JW-1:0]         job_din, job_dout;
	logic                  job_valid, job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_max_q   <= DISK_MAX_RST;
			start_head_q <= '0;
			policy_q     <= POL_FCFS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DISK_MAX:   disk_max_q   <= cfg_data;
				CFG_START_HEAD: start_head_q <= cfg_data;
				CFG_POLICY:     policy_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign busy      = back_active || !job_empty;
	assign job_valid = !job_empty;

	dss_front #(.MAX_REQUESTS(MAX_REQUESTS), .TRACK_BITS(TRACK_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.busy      (busy),
		.top       (TRACK_BITS'(disk_max_q)),
		.head_raw  (TRACK_BITS'(start_head_q)),
		.policy    (policy_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.job_push  (job_push),
		.job_data  (job_din)
	);

	dss_ram #(.W(TRACK_BITS), .D(MAX_REQUESTS), .AW(AW)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dss_fifo #(.W(JW)) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_din),
		.pop    (job_pop),
		.dout   (job_dout),
		.empty  (job_empty)
	);

	dss_back #(.MAX_REQUESTS(MAX_REQUESTS), .TRACK_BITS(TRACK_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_data  (job_dout),
		.active    (back_active),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);
endmodule

// ===== rtl/dss_ram.sv =====
`timescale 1ns / 1ps
module dss_ram #(
	parameter int W = 16,
	parameter int D = 32,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/dss_fifo.sv =====
`timescale 1ns / 1ps
module dss_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/dss_front.sv =====
`timescale 1ns / 1ps
module dss_front #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF,
	parameter int TRACK_BITS   = dss_pkg::TRACK_BITS_DEF,
	parameter int CW = $clog2(MAX_REQUESTS + 1),
	parameter int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dss_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	input  logic                            busy,
	input  logic [TRACK_BITS-1:0]           top,
	input  logic [TRACK_BITS-1:0]           head_raw,
	input  logic [1:0]                      policy,
	output logic                            ram_we,
	output logic [AW-1:0]                   ram_waddr,
	output logic [TRACK_BITS-1:0]           ram_wdata,
	output logic                            job_push,
	output logic [2+CW+2*TRACK_BITS-1:0]    job_data
);
	import dss_pkg::*;

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_next;
	logic [TRACK_BITS-1:0] trk;
	logic [TRACK_BITS-1:0] head;
	logic                  xfer;
	logic                  room;

	assign s_tready = !busy;
	assign xfer     = s_tvalid && s_tready;
	assign room     = (cnt_q < CW'(MAX_REQUESTS));
	assign trk      = TRACK_BITS'(s_tdata[TRK_W-1:0]);
	assign head     = (head_raw > top) ? top : head_raw;

	assign ram_we    = xfer && room;
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = (trk > top) ? top : trk;

	assign cnt_next = room ? cnt_q + CW'(1) : cnt_q;
	assign job_push = xfer && s_tlast;
	assign job_data = {policy, cnt_next, head, top};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (xfer) begin
			cnt_q <= s_tlast ? '0 : cnt_next;
		end
	end
endmodule

// ===== rtl/dss_back.sv =====
`timescale 1ns / 1ps
module dss_back #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF,
	parameter int TRACK_BITS   = dss_pkg::TRACK_BITS_DEF,
	parameter int CW = $clog2(MAX_REQUESTS + 1),
	parameter int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	output logic                             job_pop,
	input  logic [2+CW+2*TRACK_BITS-1:0]     job_data,
	output logic                             active,
	output logic [AW-1:0]                    ram_raddr,
	input  logic [TRACK_BITS-1:0]            ram_rdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dss_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);
	import dss_pkg::*;

	back_state_t state_q, state_d;
	seg_t        seg_q;

	logic [TRACK_BITS-1:0]   head0_q, top_q, cur_q, tgt_q, best_q;
	logic [1:0]              pol_q;
	logic [CW-1:0]           n_q, issue_q;
	logic [CW:0]             moves_q, emitted_q;
	logic [TOTAL_W-1:0]      total_q;
	logic [MAX_REQUESTS-1:0] used_q;
	logic                    rv_s1;
	logic [AW-1:0]           ridx_s1;
	logic                    found_q;
	logic [AW-1:0]           best_idx_q;

	logic                    ov_q, odone_q;
	logic [TRK_W-1:0]        ofrom_q, oto_q, odist_q;
	logic [TOTAL_W-1:0]      ototal_q;

	logic                    pass_end, out_free, issue, cand, better;
	logic [TRACK_BITS-1:0]   v, mv_dist;
	logic [1:0]              j_pol;
	logic [CW-1:0]           j_cnt;
	logic [TRACK_BITS-1:0]   j_head, j_top;

	assign {j_pol, j_cnt, j_head, j_top} = job_data;

	assign out_free = !ov_q || m_tready;
	assign issue    = (state_q == B_PASS) && (issue_q < n_q);
	assign pass_end = (issue_q == n_q) && !rv_s1;
	assign v        = ram_rdata;
	assign mv_dist  = (cur_q > tgt_q) ? cur_q - tgt_q : tgt_q - cur_q;
	assign active   = (state_q != B_IDLE);

	// candidate test for the entry coming back from the store
	always_comb begin
		cand   = 1'b0;
		better = 1'b0;
		unique case (seg_q)
			SEG_FCFS: begin
				cand   = !used_q[ridx_s1];
				better = !found_q;
			end
			SEG_HI: begin
				cand   = !used_q[ridx_s1] && (v > head0_q);
				better = !found_q || (v < best_q);
			end
			SEG_LO: begin
				cand   = !used_q[ridx_s1] && (v <= head0_q);
				better = !found_q || ((pol_q == POL_CSCAN) ? (v < best_q) : (v > best_q));
			end
			default: begin
				cand   = 1'b0;
				better = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) state_d = B_PASS;
			end
			B_PASS: begin
				if (seg_q == SEG_TOP || seg_q == SEG_ZERO) begin
					state_d = B_EMIT;
				end else if (pass_end) begin
					if (found_q) state_d = B_EMIT;
					else if (seg_q != SEG_HI) state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (out_free) begin
					state_d = (emitted_q + (CW+1)'(1) == moves_q) ? B_IDLE : B_PASS;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = (state_q == B_IDLE) && job_valid;
		ram_raddr = issue_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			seg_q   <= SEG_FCFS;
			rv_s1   <= 1'b0;
			ov_q    <= 1'b0;
			found_q <= 1'b0;
			used_q  <= '0;
			issue_q <= '0;
		end else begin
			state_q <= state_d;
			rv_s1   <= issue;
			if (issue) begin
				issue_q <= issue_q + CW'(1);
			end
			if (rv_s1 && cand && better) begin
				found_q <= 1'b1;
			end
			if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						used_q  <= '0;
						issue_q <= '0;
						found_q <= 1'b0;
						seg_q   <= (j_pol == POL_SCAN || j_pol == POL_CSCAN) ? SEG_HI : SEG_FCFS;
					end
				end
				B_PASS: begin
					if (seg_q == SEG_TOP) begin
						seg_q <= (pol_q == POL_CSCAN) ? SEG_ZERO : SEG_LO;
					end else if (seg_q == SEG_ZERO) begin
						seg_q <= SEG_LO;
					end else if (pass_end) begin
						if (found_q) begin
							used_q[best_idx_q] <= 1'b1;
						end else if (seg_q == SEG_HI) begin
							// nothing left above the head, head for the disk end
							seg_q   <= SEG_TOP;
							issue_q <= '0;
						end
					end
				end
				B_EMIT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						issue_q <= '0;
						found_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1 && cand && better) begin
			best_q     <= v;
			best_idx_q <= ridx_s1;
		end
		ridx_s1 <= issue_q[AW-1:0];
		if (state_q == B_IDLE && job_valid) begin
			pol_q     <= j_pol;
			n_q       <= j_cnt;
			head0_q   <= j_head;
			top_q     <= j_top;
			cur_q     <= j_head;
			total_q   <= '0;
			emitted_q <= '0;
			unique case (j_pol)
				POL_SCAN:  moves_q <= (CW+1)'(j_cnt) + (CW+1)'(1);
				POL_CSCAN: moves_q <= (CW+1)'(j_cnt) + (CW+1)'(2);
				default:   moves_q <= (CW+1)'(j_cnt);
			endcase
		end
		if (state_q == B_PASS) begin
			if (seg_q == SEG_TOP) tgt_q <= top_q;
			else if (seg_q == SEG_ZERO) tgt_q <= '0;
			else if (pass_end && found_q) tgt_q <= best_q;
		end
		if (state_q == B_EMIT && out_free) begin
			ofrom_q   <= TRK_W'(cur_q);
			oto_q     <= TRK_W'(tgt_q);
			odist_q   <= TRK_W'(mv_dist);
			ototal_q  <= total_q + TOTAL_W'(mv_dist);
			odone_q   <= (emitted_q + (CW+1)'(1) == moves_q);
			total_q   <= total_q + TOTAL_W'(mv_dist);
			cur_q     <= tgt_q;
			emitted_q <= emitted_q + (CW+1)'(1);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {2'b00, ototal_q, odist_q, oto_q, ofrom_q};
	assign m_tlast  = odone_q;
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import dss_pkg::*;

	typedef struct {
		logic [15:0] from_trk;
		logic [15:0] to_trk;
		logic [15:0] mv_dist;
		logic [21:0] total;
		logic        done;
	} move_rec_t;

	class seek_board;
		logic [15:0] disk_top;
		logic [15:0] head_cfg;
		logic [1:0]  pol;
		logic [15:0] batch[$];
		move_rec_t   pending[$];
		int          errors;
		int          moves_seen;

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == CFG_DISK_MAX) disk_top = val;
			else if (idx == CFG_START_HEAD) head_cfg = val;
			else if (idx == CFG_POLICY) pol = val[1:0];
		endfunction

		// one accepted request; tlast plans the whole path
		function void note_request(logic [15:0] trk, logic lst);
			logic [15:0] path[$];
			logic [15:0] hi[$];
			logic [15:0] lo[$];
			logic [15:0] head;
			logic [21:0] run;
			move_rec_t r;
			if (batch.size() < 32) batch.push_back(trk > disk_top ? disk_top : trk);
			if (!lst) return;
			head = head_cfg > disk_top ? disk_top : head_cfg;
			path.push_back(head);
			if (pol == POL_SCAN || pol == POL_CSCAN) begin
				foreach (batch[i])
					if (batch[i] > head) hi.push_back(batch[i]);
					else lo.push_back(batch[i]);
				hi.sort();
				if (pol == POL_CSCAN) lo.sort();
				else lo.rsort();
				foreach (hi[i]) path.push_back(hi[i]);
				path.push_back(disk_top);
				if (pol == POL_CSCAN) path.push_back(16'd0);
				foreach (lo[i]) path.push_back(lo[i]);
			end else begin
				foreach (batch[i]) path.push_back(batch[i]);
			end
			run = 0;
			for (int i = 0; i + 1 < path.size(); i++) begin
				r.from_trk = path[i];
				r.to_trk = path[i+1];
				r.mv_dist = path[i] > path[i+1] ? path[i] - path[i+1] : path[i+1] - path[i];
				run += 22'(r.mv_dist);
				r.total = run;
				r.done = (i + 2 == path.size());
				pending.push_back(r);
			end
			batch.delete();
		endfunction

		task check_move(logic [71:0] d, logic lst);
			move_rec_t e;
			moves_seen++;
			if (pending.size() == 0) begin
				report_err("record with nothing expected", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (d[15:0] !== e.from_trk) report_err("from_track", d[15:0], e.from_trk);
			if (d[31:16] !== e.to_trk) report_err("to_track", d[31:16], e.to_trk);
			if (d[47:32] !== e.mv_dist) report_err("distance", d[47:32], e.mv_dist);
			if (d[69:48] !== e.total) report_err("total_seek", d[69:48], e.total);
			if (lst !== e.done) report_err("done", lst, e.done);
		endtask

		task report_err(string what, longint got, longint want);
			errors++;
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
	logic [15:0] s_tdata = 0, cfg_data = 0;
	logic [1:0] cfg_index = 0;
	logic s_tready, m_tvalid, m_tlast, cfg_ready;
	logic [71:0] m_tdata;
	seek_board board;
	int batches;
	int stall_left;
	bit stall_free;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	disk_seek_scheduler DUT (.*);

	function int gap_len();
		if (stall_free) return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 30);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	// tvalid stays high across back to back requests
	task automatic send_request(logic [15:0] trk, logic lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tdata <= trk;
		s_tlast <= lst;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		board.note_request(trk, lst);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function logic [15:0] rand_track(logic [15:0] top);
		case ($urandom_range(0, 5))
			0: return 16'hFFFF;
			1: return top;
			2: return 16'd0;
			3: return 16'($urandom);
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_batch(int n, logic [15:0] top);
		for (int i = 0; i < n; i++) send_request(rand_track(top), i == n - 1);
		batches++;
	endtask

	// receiver with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_move(m_tdata, m_tlast);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!stall_free && $urandom_range(0, 3) == 0) begin
				stall_left = gap_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int sent;
		logic [15:0] top;
		board = new();
		board.disk_top = DISK_MAX_RST;
		board.head_cfg = 0;
		board.pol = POL_FCFS;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reset settings, then extremes and all policies
		send_request(16'd50, 0);
		send_request(16'hFFFF, 0);
		send_request(16'd0, 1);
		batches++;
		wait_drained();
		for (int p = 0; p < 4; p++) begin
			write_reg(CFG_POLICY, 16'(p[1:0]));
			write_reg(CFG_DISK_MAX, 16'd100);
			write_reg(CFG_START_HEAD, 16'd40);
			send_request(16'd40, 0);
			send_request(16'd90, 0);
			send_request(16'd10, 1);
			batches++;
			wait_drained();
		end
		// head at top, saturated head, single request
		write_reg(CFG_POLICY, 16'(POL_SCAN));
		write_reg(CFG_START_HEAD, 16'hFFFF);
		send_request(16'd100, 1);
		batches++;
		wait_drained();
		write_reg(CFG_POLICY, 16'(POL_CSCAN));
		write_reg(CFG_START_HEAD, 16'd0);
		write_reg(CFG_DISK_MAX, 16'hFFFF);
		send_request(16'hFFFF, 0);
		send_request(16'h8000, 1);
		batches++;
		wait_drained();
		// overfull store with dropped last request
		write_reg(CFG_POLICY, 16'(POL_SCAN));
		write_reg(CFG_DISK_MAX, 16'd0);
		send_batch(34, 16'd0);
		wait_drained();

		sent = 0;
		while (sent < 430) begin
			int n;
			stall_free = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 3))
				0: top = 16'hFFFF;
				1: top = 16'($urandom_range(0, 15));
				default: top = 16'($urandom);
			endcase
			write_reg(CFG_DISK_MAX, top);
			write_reg(CFG_START_HEAD, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
				16'($urandom_range(0, top)));
			write_reg(CFG_POLICY, 16'($urandom_range(0, 3)));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
			send_batch(n, top);
			sent += n;
			wait_drained();
		end
		stall_free = 0;
		wait_drained();
		$display("covered %0d batches over all policies, %0d move records checked",
			batches, board.moves_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
